FILE: rtl/core/pci_config_bus_enumerator_defines.svh
// ----------------------------------------------------------------------------
// pci_config_bus_enumerator_defines
// assertion macros shared by the enumerator rtl
// ----------------------------------------------------------------------------
`ifndef PCI_CONFIG_BUS_ENUMERATOR_DEFINES_SVH
`define PCI_CONFIG_BUS_ENUMERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is asserted
`define PCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pce assertion failed");
// next-cycle implication, disabled while reset is asserted
`define PCE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pce assertion failed");
`else
`define PCE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PCE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/pce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_pkg
// shared types and constants of the configuration bus enumerator
// ----------------------------------------------------------------------------
package pce_pkg;

    // request command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    // config space dword offsets
    localparam logic [7:0] OFF_IDENT  = 8'h00;
    localparam logic [7:0] OFF_CLASS  = 8'h08;
    localparam logic [7:0] OFF_HEADER = 8'h0C;
    localparam logic [7:0] OFF_MASK   = 8'hFC;

    localparam logic [15:0] ABSENT_VENDOR = 16'hFFFF;
    localparam logic [16:0] LIMIT_RESET   = 17'h10000;

    // scan phase
    typedef enum logic [1:0] {
        PH_PROBE  = 2'd0,
        PH_HEADER = 2'd1,
        PH_IDENT  = 2'd2,
        PH_CLASS  = 2'd3
    } t_phase;

    // scan state carried between requests
    typedef struct packed {
        logic        busy;
        t_phase      phase;
        logic [7:0]  bus;
        logic [4:0]  slot;
        logic [2:0]  func;
        logic        multi;
        logic [31:0] ident;
        logic [16:0] count;
    } t_scan_state;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] config_address;
        logic [7:0]  bus_number;
        logic [4:0]  slot_number;
        logic [2:0]  function_number;
        logic [15:0] vendor_code;
        logic [15:0] part_code;
        logic [7:0]  base_class;
        logic [7:0]  subclass;
        logic [7:0]  prog_if;
        logic [16:0] found_count;
        logic        last;
    } t_result;

    // results of one request, pushed into the output queue together
    typedef struct packed {
        logic [1:0] n_res;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

FILE: rtl/core/pce_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_step
// next-state and result logic for one registered request
// ----------------------------------------------------------------------------
module pce_step (
    input  logic                 i_command,
    input  logic [31:0]          i_read_data,
    input  logic [16:0]          i_record_limit,
    input  pce_pkg::t_scan_state i_state,
    output pce_pkg::t_scan_state o_state,
    output pce_pkg::t_push       o_push
);

    // config read request for the given slot and function
    function automatic pce_pkg::t_result f_read(
        input logic [7:0]  bus,
        input logic [4:0]  slot,
        input logic [2:0]  func,
        input logic [7:0]  offset,
        input logic [16:0] count
    );
        pce_pkg::t_result r;
        r = '0;
        r.kind = pce_pkg::KIND_READ;
        r.config_address = {1'b1, 7'd0, bus, slot, func, offset & pce_pkg::OFF_MASK};
        r.found_count = count;
        return r;
    endfunction

    // scan done result
    function automatic pce_pkg::t_result f_done(input logic [16:0] count);
        pce_pkg::t_result r;
        r = '0;
        r.kind = pce_pkg::KIND_DONE;
        r.found_count = count;
        return r;
    endfunction

    logic [16:0]          w_count_inc;
    logic [16:0]          w_count_eff;
    logic                 w_limit;
    logic                 w_go_slot;
    logic                 w_slot_wrap;
    logic                 w_bus_end;
    logic [7:0]           w_bus_next;
    logic [4:0]           w_slot_next;
    logic [2:0]           w_func_next;
    logic                 w_absent;
    pce_pkg::t_scan_state w_adv_state;
    pce_pkg::t_result     w_adv_res;
    pce_pkg::t_result     w_record;

    // counters and limit check against the count as it stands after this request
    assign w_count_inc = i_state.count + 17'd1;
    assign w_count_eff = (i_state.phase == pce_pkg::PH_CLASS) ? w_count_inc : i_state.count;
    assign w_limit     = (w_count_eff >= i_record_limit);
    assign w_absent    = (i_read_data[15:0] == pce_pkg::ABSENT_VENDOR);

    // position stepping
    assign w_slot_wrap = (i_state.slot == 5'd31);
    assign w_bus_end   = w_slot_wrap && (i_state.bus == 8'd255);
    assign w_bus_next  = w_slot_wrap ? (i_state.bus + 8'd1) : i_state.bus;
    assign w_slot_next = w_slot_wrap ? 5'd0 : (i_state.slot + 5'd1);
    assign w_func_next = i_state.func + 3'd1;
    assign w_go_slot   = (i_state.phase == pce_pkg::PH_PROBE) || !i_state.multi ||
                         (i_state.func == 3'd7);

    // move on to the next function, or the next slot when functions run out; done at the last slot or the limit
    always_comb begin
        w_adv_state = i_state;
        w_adv_state.count = w_count_eff;
        if (w_go_slot) begin
            w_adv_state.slot = w_slot_next;
            if (w_bus_end) begin
                w_adv_state.busy = 1'b0;
                w_adv_res = f_done(w_count_eff);
            end else if (w_limit) begin
                w_adv_state.bus  = w_bus_next;
                w_adv_state.busy = 1'b0;
                w_adv_res = f_done(w_count_eff);
            end else begin
                w_adv_state.bus   = w_bus_next;
                w_adv_state.func  = 3'd0;
                w_adv_state.phase = pce_pkg::PH_PROBE;
                w_adv_res = f_read(w_bus_next, w_slot_next, 3'd0, pce_pkg::OFF_IDENT,
                                   w_count_eff);
            end
        end else if (w_limit) begin
            w_adv_state.busy = 1'b0;
            w_adv_res = f_done(w_count_eff);
        end else begin
            w_adv_state.func  = w_func_next;
            w_adv_state.phase = pce_pkg::PH_IDENT;
            w_adv_res = f_read(i_state.bus, i_state.slot, w_func_next, pce_pkg::OFF_IDENT,
                               w_count_eff);
        end
    end

    // device record from the saved identification and the class dword
    always_comb begin
        w_record = '0;
        w_record.kind            = pce_pkg::KIND_RECORD;
        w_record.bus_number      = i_state.bus;
        w_record.slot_number     = i_state.slot;
        w_record.function_number = i_state.func;
        w_record.vendor_code     = i_state.ident[15:0];
        w_record.part_code       = i_state.ident[31:16];
        w_record.base_class      = i_read_data[31:24];
        w_record.subclass        = i_read_data[23:16];
        w_record.prog_if         = i_read_data[15:8];
        w_record.found_count     = w_count_inc;
    end

    // per-request dispatch
    always_comb begin
        o_state = i_state;
        o_push  = '0;
        if (i_command == pce_pkg::CMD_START) begin
            o_state = '0;
            o_state.busy = 1'b1;
            o_push.n_res = 2'd1;
            if (i_record_limit == 17'd0) begin
                o_state.busy = 1'b0;
                o_push.res0 = f_done(17'd0);
            end else begin
                o_push.res0 = f_read(8'd0, 5'd0, 3'd0, pce_pkg::OFF_IDENT, 17'd0);
            end
        end else if (i_state.busy) begin
            o_push.n_res = 2'd1;
            case (i_state.phase)
                pce_pkg::PH_PROBE: begin
                    if (w_absent) begin
                        o_state = w_adv_state;
                        o_push.res0 = w_adv_res;
                    end else begin
                        o_state.phase = pce_pkg::PH_HEADER;
                        o_push.res0 = f_read(i_state.bus, i_state.slot, i_state.func,
                                             pce_pkg::OFF_HEADER, i_state.count);
                    end
                end
                pce_pkg::PH_HEADER: begin
                    o_state.multi = i_read_data[23];
                    o_state.func  = 3'd0;
                    if (w_limit) begin
                        o_state.busy = 1'b0;
                        o_push.res0 = f_done(i_state.count);
                    end else begin
                        o_state.phase = pce_pkg::PH_IDENT;
                        o_push.res0 = f_read(i_state.bus, i_state.slot, 3'd0,
                                             pce_pkg::OFF_IDENT, i_state.count);
                    end
                end
                pce_pkg::PH_IDENT: begin
                    if (w_absent) begin
                        o_state = w_adv_state;
                        o_push.res0 = w_adv_res;
                    end else begin
                        o_state.ident = i_read_data;
                        o_state.phase = pce_pkg::PH_CLASS;
                        o_push.res0 = f_read(i_state.bus, i_state.slot, i_state.func,
                                             pce_pkg::OFF_CLASS, i_state.count);
                    end
                end
                pce_pkg::PH_CLASS: begin
                    o_push.n_res = 2'd2;
                    o_push.res0  = w_record;
                    if (w_limit) begin
                        o_state.count = w_count_inc;
                        o_state.busy  = 1'b0;
                        o_push.res1   = f_done(w_count_inc);
                    end else begin
                        o_state = w_adv_state;
                        o_push.res1 = w_adv_res;
                    end
                end
                default: begin
                    o_push.n_res = 2'd0;
                end
            endcase
        end
        // flag the final result of this request
        if (o_push.n_res == 2'd2) begin
            o_push.res1.last = 1'b1;
        end else if (o_push.n_res == 2'd1) begin
            o_push.res0.last = 1'b1;
        end
    end

endmodule

FILE: rtl/core/pce_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pce_out_queue
// four-entry result queue, takes up to two results per cycle, gives one
// ----------------------------------------------------------------------------
module pce_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pce_pkg::t_push   i_push,
    output logic             o_space_ok,
    output logic             o_valid,
    input  logic             i_ready,
    output pce_pkg::t_result o_head
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    pce_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_count;
    logic             w_pop;

    assign o_valid    = (r_count != '0);
    assign o_head     = r_mem[r_rp];
    assign w_pop      = o_valid && i_ready;
    assign o_space_ok = (r_count <= (AW+1)'(DEPTH - 2));

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + AW'(i_push.n_res);
            r_rp    <= r_rp + AW'(w_pop);
            r_count <= r_count + (AW+1)'(i_push.n_res) - (AW+1)'(w_pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.n_res != 2'd0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (i_push.n_res == 2'd2) begin
            r_mem[r_wp + AW'(1)] <= i_push.res1;
        end
    end

endmodule

FILE: rtl/core/pci_config_bus_enumerator.sv
`timescale 1ns / 1ps
// flow: a request is registered, then its results enter the output queue once the queue
// has room for two results
// throughput: one request per cycle unless stalled; a record plus its follow-up leaves as two
// results, and requests stall while the queue holds more than two results
// reset: synchronous active low; clears the scan state and the queue, and sets the record
// limit to 65536
// ----------------------------------------------------------------------------
// pci_config_bus_enumerator
// brute-force pci configuration space scan driven by config read responses
// ----------------------------------------------------------------------------
`include "pci_config_bus_enumerator_defines.svh"

module pci_config_bus_enumerator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [31:0] i_read_data,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_config_address,
    output logic [7:0]  o_bus_number,
    output logic [4:0]  o_slot_number,
    output logic [2:0]  o_function_number,
    output logic [15:0] o_vendor_code,
    output logic [15:0] o_part_code,
    output logic [7:0]  o_base_class,
    output logic [7:0]  o_subclass,
    output logic [7:0]  o_prog_if,
    output logic [16:0] o_found_count,
    output logic        o_last,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data
);

    logic                 r_in_valid;
    logic                 r_in_cmd;
    logic [31:0]          r_in_data;
    logic [16:0]          r_record_limit;
    pce_pkg::t_scan_state r_state;
    pce_pkg::t_scan_state w_step_state;
    pce_pkg::t_push       w_step_push;
    pce_pkg::t_push       w_push;
    pce_pkg::t_result     w_head;
    logic                 w_space_ok;
    logic                 w_consume;

    // the registered request is processed once the queue can take two results
    assign w_consume = r_in_valid && w_space_ok;
    assign o_ready   = !r_in_valid || w_space_ok;
    assign o_cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_limit <= pce_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_record_limit <= i_cfg_data;
        end
    end

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_cmd  <= i_command;
            r_in_data <= i_read_data;
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_consume) begin
            r_state <= w_step_state;
        end
    end

    pce_step u_step (
        .i_command      (r_in_cmd),
        .i_read_data    (r_in_data),
        .i_record_limit (r_record_limit),
        .i_state        (r_state),
        .o_state        (w_step_state),
        .o_push         (w_step_push)
    );

    // only push when the request is actually taken
    always_comb begin
        w_push = w_step_push;
        if (!w_consume) begin
            w_push.n_res = 2'd0;
        end
    end

    pce_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_space_ok (w_space_ok),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_head     (w_head)
    );

    // result fields
    assign o_kind            = w_head.kind;
    assign o_config_address  = w_head.config_address;
    assign o_bus_number      = w_head.bus_number;
    assign o_slot_number     = w_head.slot_number;
    assign o_function_number = w_head.function_number;
    assign o_vendor_code     = w_head.vendor_code;
    assign o_part_code       = w_head.part_code;
    assign o_base_class      = w_head.base_class;
    assign o_subclass        = w_head.subclass;
    assign o_prog_if         = w_head.prog_if;
    assign o_found_count     = w_head.found_count;
    assign o_last            = w_head.last;

    // a start clears the position and the record count
    `PCE_ASSERT_NXT(a_start_clears, i_clk, i_rst_n,
        w_consume && (r_in_cmd == pce_pkg::CMD_START),
        (r_state.count == 17'd0) && (r_state.bus == 8'd0) && (r_state.slot == 5'd0))
    // data while idle produces nothing
    `PCE_ASSERT_IMP(a_idle_silent, i_clk, i_rst_n,
        w_consume && (r_in_cmd == pce_pkg::CMD_DATA) && !r_state.busy,
        w_push.n_res == 2'd0)
    // a done result ends the scan
    `PCE_ASSERT_NXT(a_done_idles, i_clk, i_rst_n,
        w_consume && (((w_push.n_res == 2'd1) && (w_push.res0.kind == pce_pkg::KIND_DONE))
            || ((w_push.n_res == 2'd2) && (w_push.res1.kind == pce_pkg::KIND_DONE))),
        !r_state.busy)
    // a record is always followed by a second result of the same request
    `PCE_ASSERT_IMP(a_record_pair, i_clk, i_rst_n,
        w_consume && (w_push.n_res != 2'd0) && (w_push.res0.kind == pce_pkg::KIND_RECORD),
        w_push.n_res == 2'd2)

endmodule

FILE: bench/pci_config_bus_enumerator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pci_config_bus_enumerator_checker
// tracks the scan state from accepted requests and limit writes, predicts the
// read requests, device records and done results, and compares them in order
// ----------------------------------------------------------------------------
module pci_config_bus_enumerator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic        i_command,
    input  logic [31:0] i_read_data,
    // result channel
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_config_address,
    input  logic [7:0]  i_bus_number,
    input  logic [4:0]  i_slot_number,
    input  logic [2:0]  i_function_number,
    input  logic [15:0] i_vendor_code,
    input  logic [15:0] i_part_code,
    input  logic [7:0]  i_base_class,
    input  logic [7:0]  i_subclass,
    input  logic [7:0]  i_prog_if,
    input  logic [16:0] i_found_count,
    input  logic        i_last,
    // limit write channel
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [16:0] i_cfg_data,
    // status for the test top
    output int          o_fail_count,
    output int          o_pending,
    output int          o_records_seen,
    output int          o_scans_done
);

    // scan state mirror
    logic             scan_busy;
    pce_pkg::t_phase  scan_phase;
    logic [7:0]       scan_bus;
    logic [4:0]       scan_slot;
    logic [2:0]       scan_func;
    logic             scan_multi;
    logic [31:0]      scan_ident;
    logic [16:0]      scan_count;
    logic [16:0]      device_limit;

    pce_pkg::t_result step_results[$];
    pce_pkg::t_result expected_results[$];
    int               mismatch_count;
    int               records_seen;
    int               scans_done;

    function automatic pce_pkg::t_result blank_result(input logic [1:0] kind_code);
        pce_pkg::t_result r;
        r = '0;
        r.kind = kind_code;
        r.found_count = scan_count;
        return r;
    endfunction

    function automatic logic limit_reached();
        return scan_count >= device_limit;
    endfunction

    task automatic clear_scan();
        scan_busy  = 1'b0;
        scan_phase = pce_pkg::PH_PROBE;
        scan_bus   = '0;
        scan_slot  = '0;
        scan_func  = '0;
        scan_multi = 1'b0;
        scan_ident = '0;
        scan_count = '0;
    endtask

    task automatic issue_read(input logic [7:0] offset);
        pce_pkg::t_result r;
        r = blank_result(pce_pkg::KIND_READ);
        r.config_address = {1'b1, 7'd0, scan_bus, scan_slot, scan_func,
                            offset & pce_pkg::OFF_MASK};
        step_results.push_back(r);
    endtask

    task automatic close_scan();
        step_results.push_back(blank_result(pce_pkg::KIND_DONE));
        scan_busy = 1'b0;
    endtask

    // move to the next slot, wrapping into the next bus; close the scan at the last bus or the limit
    task automatic advance_slot();
        logic finished;
        finished = 1'b0;
        if (scan_slot == 5'd31) begin
            scan_slot = '0;
            if (scan_bus == 8'd255) begin
                close_scan();
                finished = 1'b1;
            end else begin
                scan_bus = scan_bus + 8'd1;
            end
        end else begin
            scan_slot = scan_slot + 5'd1;
        end
        if (!finished) begin
            if (limit_reached()) begin
                close_scan();
            end else begin
                scan_func  = '0;
                scan_phase = pce_pkg::PH_PROBE;
                issue_read(pce_pkg::OFF_IDENT);
            end
        end
    endtask

    task automatic advance_function();
        if (!scan_multi || scan_func == 3'd7) begin
            advance_slot();
        end else if (limit_reached()) begin
            close_scan();
        end else begin
            scan_func  = scan_func + 3'd1;
            scan_phase = pce_pkg::PH_IDENT;
            issue_read(pce_pkg::OFF_IDENT);
        end
    endtask

    // expected results of one accepted request, last flag on the final one
    task automatic predict_request(input logic command, input logic [31:0] data);
        pce_pkg::t_result r;
        step_results.delete();
        if (command == pce_pkg::CMD_START) begin
            clear_scan();
            scan_busy = 1'b1;
            if (limit_reached()) begin
                close_scan();
            end else begin
                issue_read(pce_pkg::OFF_IDENT);
            end
        end else if (scan_busy) begin
            case (scan_phase)
                pce_pkg::PH_PROBE: begin
                    if (data[15:0] == pce_pkg::ABSENT_VENDOR) begin
                        advance_slot();
                    end else begin
                        scan_phase = pce_pkg::PH_HEADER;
                        issue_read(pce_pkg::OFF_HEADER);
                    end
                end
                pce_pkg::PH_HEADER: begin
                    scan_multi = data[23];
                    scan_func  = '0;
                    if (limit_reached()) begin
                        close_scan();
                    end else begin
                        scan_phase = pce_pkg::PH_IDENT;
                        issue_read(pce_pkg::OFF_IDENT);
                    end
                end
                pce_pkg::PH_IDENT: begin
                    if (data[15:0] == pce_pkg::ABSENT_VENDOR) begin
                        advance_function();
                    end else begin
                        scan_ident = data;
                        scan_phase = pce_pkg::PH_CLASS;
                        issue_read(pce_pkg::OFF_CLASS);
                    end
                end
                default: begin
                    scan_count = scan_count + 17'd1;
                    r = blank_result(pce_pkg::KIND_RECORD);
                    r.bus_number      = scan_bus;
                    r.slot_number     = scan_slot;
                    r.function_number = scan_func;
                    r.vendor_code     = scan_ident[15:0];
                    r.part_code       = scan_ident[31:16];
                    r.base_class      = data[31:24];
                    r.subclass        = data[23:16];
                    r.prog_if         = data[15:8];
                    step_results.push_back(r);
                    if (limit_reached()) begin
                        close_scan();
                    end else begin
                        advance_function();
                    end
                end
            endcase
        end
        for (int k = 0; k < step_results.size(); k++) begin
            r = step_results[k];
            r.last = (k == step_results.size() - 1);
            expected_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic compare_result();
        pce_pkg::t_result want;
        if (expected_results.size() == 0) begin
            $error("result: kind %0d arrived with nothing expected", i_kind);
            mismatch_count++;
        end else begin
            want = expected_results.pop_front();
            check_field("kind", 32'(want.kind), 32'(i_kind));
            check_field("config_address", want.config_address, i_config_address);
            check_field("bus_number", 32'(want.bus_number), 32'(i_bus_number));
            check_field("slot_number", 32'(want.slot_number), 32'(i_slot_number));
            check_field("function_number", 32'(want.function_number),
                        32'(i_function_number));
            check_field("vendor_code", 32'(want.vendor_code), 32'(i_vendor_code));
            check_field("part_code", 32'(want.part_code), 32'(i_part_code));
            check_field("base_class", 32'(want.base_class), 32'(i_base_class));
            check_field("subclass", 32'(want.subclass), 32'(i_subclass));
            check_field("prog_if", 32'(want.prog_if), 32'(i_prog_if));
            check_field("found_count", 32'(want.found_count), 32'(i_found_count));
            check_field("last", 32'(want.last), 32'(i_last));
            if (want.kind == pce_pkg::KIND_RECORD) records_seen++;
            if (want.kind == pce_pkg::KIND_DONE) scans_done++;
        end
    endtask

    // results leave before new predictions enter, limit writes land in between
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
            device_limit = pce_pkg::LIMIT_RESET;
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) compare_result();
            if (i_cfg_valid && i_cfg_ready) device_limit = i_cfg_data;
            if (i_req_valid && i_req_ready) predict_request(i_command, i_read_data);
        end
        o_fail_count   <= mismatch_count;
        o_pending      <= expected_results.size();
        o_records_seen <= records_seen;
        o_scans_done   <= scans_done;
    end

endmodule

FILE: bench/pci_config_bus_enumerator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pci_config_bus_enumerator_test
// plays the configuration space behind the enumerator: directed corner cases,
// a sweep across the first buses, then random device trees with noise and limit
// changes; a checker beside the block compares every result
// ----------------------------------------------------------------------------
module pci_config_bus_enumerator_test;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_REQUESTS = 1650;
    localparam int SWEEP_BUSES     = 4;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic        req_command;
    logic [31:0] req_read_data;
    logic        res_valid;
    logic        res_ready;
    logic [1:0]  res_kind;
    logic [31:0] res_config_address;
    logic [7:0]  res_bus_number;
    logic [4:0]  res_slot_number;
    logic [2:0]  res_function_number;
    logic [15:0] res_vendor_code;
    logic [15:0] res_part_code;
    logic [7:0]  res_base_class;
    logic [7:0]  res_subclass;
    logic [7:0]  res_prog_if;
    logic [16:0] res_found_count;
    logic        res_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [16:0] cfg_data;

    int          fail_count;
    int          pending;
    int          records_seen;
    int          scans_done;
    int          requests_sent;
    int          limit_writes;
    int          idle_cycles;
    int          ready_hold;
    int          res_gap;
    logic        no_idle;

    pci_config_bus_enumerator u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (req_valid),
        .o_ready           (req_ready),
        .i_command         (req_command),
        .i_read_data       (req_read_data),
        .o_valid           (res_valid),
        .i_ready           (res_ready),
        .o_kind            (res_kind),
        .o_config_address  (res_config_address),
        .o_bus_number      (res_bus_number),
        .o_slot_number     (res_slot_number),
        .o_function_number (res_function_number),
        .o_vendor_code     (res_vendor_code),
        .o_part_code       (res_part_code),
        .o_base_class      (res_base_class),
        .o_subclass        (res_subclass),
        .o_prog_if         (res_prog_if),
        .o_found_count     (res_found_count),
        .o_last            (res_last),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_data        (cfg_data)
    );

    pci_config_bus_enumerator_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_req_valid       (req_valid),
        .i_req_ready       (req_ready),
        .i_command         (req_command),
        .i_read_data       (req_read_data),
        .i_res_valid       (res_valid),
        .i_res_ready       (res_ready),
        .i_kind            (res_kind),
        .i_config_address  (res_config_address),
        .i_bus_number      (res_bus_number),
        .i_slot_number     (res_slot_number),
        .i_function_number (res_function_number),
        .i_vendor_code     (res_vendor_code),
        .i_part_code       (res_part_code),
        .i_base_class      (res_base_class),
        .i_subclass        (res_subclass),
        .i_prog_if         (res_prog_if),
        .i_found_count     (res_found_count),
        .i_last            (res_last),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_data        (cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_records_seen    (records_seen),
        .o_scans_done      (scans_done)
    );

    // 100 MHz clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side stall, drawn after every accepted result; a zero draw keeps ready high
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ready  <= 1'b0;
            ready_hold <= 0;
        end else if (res_ready) begin
            if (res_valid) begin
                res_gap = no_idle ? 0 : int'($urandom_range(0, 5));
                if (res_gap != 0) begin
                    ready_hold <= res_gap - 1;
                    res_ready  <= 1'b0;
                end
            end
        end else if (ready_hold == 0) begin
            res_ready <= 1'b1;
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    // watchdog on cycles without any accepted transfer
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (res_valid && res_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[pci_config_bus_enumerator] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one request with a random gap in front of it
    task automatic send_req(input logic command, input logic [31:0] data);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 5));
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid     <= 1'b1;
        req_command   <= command;
        req_read_data <= data;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        requests_sent++;
    endtask

    // drain all expected results, then let the pipeline run empty
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input logic [16:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        limit_writes++;
    endtask

    function automatic logic [31:0] present_dword();
        logic [31:0] d;
        d = $urandom;
        if (d[15:0] == pce_pkg::ABSENT_VENDOR) d[15:0] = 16'($urandom_range(0, 16'hFFFE));
        return d;
    endfunction

    function automatic logic [31:0] absent_dword();
        logic [31:0] d;
        d = $urandom;
        d[15:0] = pce_pkg::ABSENT_VENDOR;
        return d;
    endfunction

    // responses for one populated slot: probe, header, then each function
    task automatic send_device(input logic multi, input logic [7:0] fn_mask);
        logic [31:0] header;
        int          fn_total;
        header = $urandom;
        header[23] = multi;
        fn_total = multi ? 8 : 1;
        send_req(pce_pkg::CMD_DATA, present_dword());
        send_req(pce_pkg::CMD_DATA, header);
        for (int f = 0; f < fn_total; f++) begin
            if (fn_mask[f]) begin
                send_req(pce_pkg::CMD_DATA, present_dword());
                send_req(pce_pkg::CMD_DATA, $urandom);
            end else begin
                send_req(pce_pkg::CMD_DATA, absent_dword());
            end
        end
    endtask

    function automatic logic [16:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return 17'd0;
            1:       return pce_pkg::LIMIT_RESET;
            2:       return 17'h0FFFF;
            3:       return 17'($urandom_range(0, 65536));
            default: return 17'($urandom_range(1, 12));
        endcase
    endfunction

    initial begin
        int random_base;
        int slot_total;
        rst_n         <= 1'b0;
        req_valid     <= 1'b0;
        req_command   <= pce_pkg::CMD_START;
        req_read_data <= '0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        no_idle       <= 1'b0;
        requests_sent = 0;
        limit_writes  = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // multi-function slot, absent function, extreme dwords, restart while busy
        send_req(pce_pkg::CMD_START, 32'h0000_0000);
        send_req(pce_pkg::CMD_DATA, 32'hFFFF_0000);
        send_req(pce_pkg::CMD_DATA, 32'h0080_0000);
        send_req(pce_pkg::CMD_DATA, 32'h0000_FFFF);
        send_req(pce_pkg::CMD_DATA, 32'hFFFF_FFFE);
        send_req(pce_pkg::CMD_DATA, 32'hFFFF_FFFF);
        send_req(pce_pkg::CMD_START, 32'hFFFF_FFFF);
        send_req(pce_pkg::CMD_DATA, 32'h0000_FFFF);
        send_req(pce_pkg::CMD_DATA, 32'h1234_5678);
        send_req(pce_pkg::CMD_DATA, 32'hFF7F_FFFF);
        send_req(pce_pkg::CMD_DATA, 32'h5678_1234);
        send_req(pce_pkg::CMD_DATA, 32'h0000_0000);

        // zero limit finishes at once, data after that is dropped
        write_limit(17'd0);
        send_req(pce_pkg::CMD_START, 32'h0000_0000);
        send_req(pce_pkg::CMD_DATA, $urandom);

        // the first record reaches the limit
        write_limit(17'd1);
        send_req(pce_pkg::CMD_START, 32'h0000_0000);
        send_device(1'b0, 8'h01);

        // limit lowered mid-scan, hit on the next function step
        write_limit(17'd2);
        send_req(pce_pkg::CMD_START, 32'h0000_0000);
        send_req(pce_pkg::CMD_DATA, present_dword());
        send_req(pce_pkg::CMD_DATA, 32'hFFFF_FFFF);
        send_req(pce_pkg::CMD_DATA, present_dword());
        send_req(pce_pkg::CMD_DATA, $urandom);
        write_limit(17'd1);
        send_req(pce_pkg::CMD_DATA, absent_dword());

        // limit dropped to zero before the header read
        write_limit(pce_pkg::LIMIT_RESET);
        send_req(pce_pkg::CMD_START, 32'h0000_0000);
        send_req(pce_pkg::CMD_DATA, present_dword());
        write_limit(17'd0);
        send_req(pce_pkg::CMD_DATA, $urandom);

        // sweep across the first buses, slot wrap into the next bus
        write_limit(pce_pkg::LIMIT_RESET);
        send_req(pce_pkg::CMD_START, $urandom);
        for (int b = 0; b < SWEEP_BUSES; b++) begin
            for (int s = 0; s < 32; s++) begin
                if (b == 2 && s == 0) no_idle <= 1'b1;
                if ($urandom_range(0, 15) == 0 ||
                    (s == 31 && (b == 0 || b == SWEEP_BUSES - 1))) begin
                    send_device(1'($urandom_range(0, 1)), 8'($urandom));
                end else begin
                    send_req(pce_pkg::CMD_DATA, absent_dword());
                end
            end
        end
        send_req(pce_pkg::CMD_DATA, $urandom);

        // random device trees, noise and limit changes between bursts
        random_base = requests_sent;
        while (requests_sent < random_base + RANDOM_REQUESTS) begin
            settle();
            no_idle <= ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 1) write_limit(pick_limit());
            if ($urandom_range(0, 19) != 0) send_req(pce_pkg::CMD_START, $urandom);
            slot_total = $urandom_range(1, 20);
            for (int s = 0; s < slot_total; s++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: send_req(pce_pkg::CMD_DATA, absent_dword());
                    3:       send_req(1'($urandom_range(0, 1)), $urandom);
                    default: send_device(1'($urandom_range(0, 1)), 8'($urandom));
                endcase
            end
        end

        settle();
        repeat (10) @(posedge clk);
        $display("run covered %0d requests and %0d limit writes, a sweep over %0d buses",
                 requests_sent, limit_writes, SWEEP_BUSES);
        $display("checked %0d device records and %0d finished scans", records_seen, scans_done);
        if (fail_count == 0 && pending == 0) begin
            $display("[pci_config_bus_enumerator] OK");
        end else begin
            $display("[pci_config_bus_enumerator] ERROR");
        end
        $finish;
    end

endmodule
